// ===== hdl/sd_spi_block_transfer_sequencer_core_defines.svh =====
// Assertion macros for the SD SPI block transfer sequencer.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef SD_SPI_BLOCK_TRANSFER_SEQUENCER_CORE_DEFINES_SVH
`define SD_SPI_BLOCK_TRANSFER_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SDSPI_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("sdspi: invariant violated");
`define SDSPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sdspi: sequence violated");
`else
`define SDSPI_ASSERT_ALWAYS(label, expr)
`define SDSPI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hdl/sdspi_pkg.sv =====
// Types, constants and codes of the SD SPI block transfer sequencer.
// No dependencies; used by sdspi_step and the core top level.
package sdspi_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int BLOCK_SHIFT = 9;
    localparam int CID_BYTES   = 16;
    localparam int WAKE_BYTES  = 16;
    localparam int CMD_BYTES   = 6;
    localparam int CRC_BYTES   = 2;

    localparam int BC_MAX_A = (BLOCK_BYTES > WAKE_BYTES) ? BLOCK_BYTES : WAKE_BYTES;
    localparam int BC_MAX   = (BC_MAX_A > CID_BYTES) ? BC_MAX_A : CID_BYTES;
    localparam int BC_W     = $clog2(BC_MAX + 1);

    localparam logic [7:0] IDLE_BYTE  = 8'hFF;
    localparam logic [7:0] DATA_TOKEN = 8'hFE;
    localparam logic [7:0] CRC_CMD0   = 8'h95;
    localparam logic [7:0] R1_IDLE    = 8'h01;
    localparam logic [7:0] R1_READY   = 8'h00;
    localparam logic [7:0] RESP_MASK  = 8'h1F;
    localparam logic [7:0] RESP_OK    = 8'h05;
    localparam logic [7:0] BUSY_BYTE  = 8'h00;

    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_SEND_OP   = 6'd1;
    localparam logic [5:0] CMD_SEND_CID  = 6'd10;
    localparam logic [5:0] CMD_READ_ONE  = 6'd17;
    localparam logic [5:0] CMD_WRITE_ONE = 6'd24;
    localparam logic [1:0] CMD_PREFIX    = 2'b01;

    localparam logic [2:0] OP_XCHG  = 3'd0;
    localparam logic [2:0] OP_INIT  = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_CID   = 3'd4;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    localparam logic [15:0] RETRY_MAX = 16'hFFFF;

    localparam logic [7:0]  POLL_LIMIT_RST  = 8'd201;
    localparam logic [15:0] RETRY_LIMIT_RST = 16'hFFFE;

    localparam logic CFG_POLL_LIMIT  = 1'b0;
    localparam logic CFG_RETRY_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        KIND_INIT  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_CID   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE, PH_WAKE, PH_CMD_IDLE, PH_CMD_SEND, PH_CMD_POLL,
        PH_CID_DATA, PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC,
        PH_WR_FILL, PH_WR_TOKEN, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY
    } t_phase;

    typedef struct packed {
        logic [2:0]  operation;
        logic [22:0] block_address;
        logic [7:0]  card_byte;
        logic [7:0]  write_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] send_byte;
        logic       send_valid;
        logic       select_active;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       need_write_byte;
        logic [1:0] status;
        logic       fast_clock;
    } t_result;

    typedef struct packed {
        logic [7:0]  reply_poll_limit;
        logic [15:0] init_retry_limit;
    } t_cfg;

    typedef struct packed {
        t_phase          phase;
        t_kind           kind;
        logic [BC_W-1:0] byte_counter;
        logic [7:0]      poll_counter;
        logic [15:0]     retry_counter;
        logic [31:0]     byte_address;
        logic            speed_flag;
        logic [5:0]      cmd_code;
        logic            select_level;
        logic [1:0]      held_status;
    } t_state;

endpackage

// ===== hdl/sdspi_step.sv =====
// Next-state and result logic for one word of the SD SPI sequencer.
// Purely combinational; uses sdspi_pkg types and constants.
module sdspi_step (
    input  sdspi_pkg::t_state  i_state,
    input  sdspi_pkg::t_item   i_item,
    input  sdspi_pkg::t_cfg    i_cfg,
    output sdspi_pkg::t_state  o_state,
    output sdspi_pkg::t_result o_result
);

    function automatic logic [7:0] cmd_byte(input logic [5:0] cmd, input logic [31:0] addr,
                                            input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = {sdspi_pkg::CMD_PREFIX, cmd};
            3'd1: b = addr[31:24];
            3'd2: b = addr[23:16];
            3'd3: b = addr[15:8];
            3'd4: b = addr[7:0];
            default: b = (cmd == sdspi_pkg::CMD_GO_IDLE) ? sdspi_pkg::CRC_CMD0
                                                         : sdspi_pkg::IDLE_BYTE;
        endcase
        return b;
    endfunction

    sdspi_pkg::t_state       n;
    logic [7:0]              send;
    logic                    sv;
    logic                    rv;
    logic [7:0]              rb;
    logic                    nw;
    logic                    do_start;
    logic [5:0]              start_code;
    logic                    do_finish;
    logic [1:0]              fin_st;
    logic [sdspi_pkg::BC_W-1:0] bc_inc;
    logic [7:0]              b;

    assign bc_inc = i_state.byte_counter + sdspi_pkg::BC_W'(1);
    assign b      = i_item.card_byte;

    always_comb begin
        n          = i_state;
        send       = 8'h00;
        sv         = 1'b0;
        rv         = 1'b0;
        rb         = 8'h00;
        nw         = 1'b0;
        do_start   = 1'b0;
        start_code = sdspi_pkg::CMD_GO_IDLE;
        do_finish  = 1'b0;
        fin_st     = sdspi_pkg::ST_BUSY;

        if (i_item.operation == sdspi_pkg::OP_INIT || i_item.operation == sdspi_pkg::OP_READ ||
            i_item.operation == sdspi_pkg::OP_WRITE || i_item.operation == sdspi_pkg::OP_CID) begin
            n.held_status   = sdspi_pkg::ST_BUSY;
            n.retry_counter = 16'd0;
            n.byte_counter  = '0;
            case (i_item.operation)
                sdspi_pkg::OP_INIT: begin
                    n.kind         = sdspi_pkg::KIND_INIT;
                    n.byte_address = 32'd0;
                    n.select_level = 1'b0;
                    n.phase        = sdspi_pkg::PH_WAKE;
                    send = sdspi_pkg::IDLE_BYTE;
                    sv   = 1'b1;
                end
                sdspi_pkg::OP_CID: begin
                    n.kind         = sdspi_pkg::KIND_CID;
                    n.byte_address = 32'd0;
                    do_start   = 1'b1;
                    start_code = sdspi_pkg::CMD_SEND_CID;
                end
                sdspi_pkg::OP_READ: begin
                    n.kind         = sdspi_pkg::KIND_READ;
                    n.byte_address = 32'(i_item.block_address) << sdspi_pkg::BLOCK_SHIFT;
                    do_start   = 1'b1;
                    start_code = sdspi_pkg::CMD_READ_ONE;
                end
                default: begin
                    n.kind         = sdspi_pkg::KIND_WRITE;
                    n.byte_address = 32'(i_item.block_address) << sdspi_pkg::BLOCK_SHIFT;
                    do_start   = 1'b1;
                    start_code = sdspi_pkg::CMD_WRITE_ONE;
                end
            endcase
        end else if (i_item.operation == sdspi_pkg::OP_XCHG &&
                     i_state.phase != sdspi_pkg::PH_IDLE) begin
            case (i_state.phase)
                sdspi_pkg::PH_WAKE: begin
                    n.byte_counter = bc_inc;
                    if (bc_inc < sdspi_pkg::BC_W'(sdspi_pkg::WAKE_BYTES)) begin
                        send = sdspi_pkg::IDLE_BYTE;
                        sv   = 1'b1;
                    end else begin
                        do_start   = 1'b1;
                        start_code = sdspi_pkg::CMD_GO_IDLE;
                    end
                end
                sdspi_pkg::PH_CMD_IDLE: begin
                    n.select_level = 1'b1;
                    n.phase        = sdspi_pkg::PH_CMD_SEND;
                    n.byte_counter = sdspi_pkg::BC_W'(1);
                    send = cmd_byte(i_state.cmd_code, i_state.byte_address, 3'd0);
                    sv   = 1'b1;
                end
                sdspi_pkg::PH_CMD_SEND: begin
                    if (i_state.byte_counter < sdspi_pkg::BC_W'(sdspi_pkg::CMD_BYTES)) begin
                        send = cmd_byte(i_state.cmd_code, i_state.byte_address,
                                        i_state.byte_counter[2:0]);
                        sv   = 1'b1;
                        n.byte_counter = bc_inc;
                    end else begin
                        n.phase        = sdspi_pkg::PH_CMD_POLL;
                        n.poll_counter = 8'd0;
                        send = sdspi_pkg::IDLE_BYTE;
                        sv   = 1'b1;
                    end
                end
                sdspi_pkg::PH_CMD_POLL: begin
                    if (b == sdspi_pkg::IDLE_BYTE &&
                        i_state.poll_counter < i_cfg.reply_poll_limit) begin
                        n.poll_counter = i_state.poll_counter + 8'd1;
                        send = sdspi_pkg::IDLE_BYTE;
                        sv   = 1'b1;
                    end else if (i_state.kind == sdspi_pkg::KIND_INIT) begin
                        if (i_state.cmd_code == sdspi_pkg::CMD_GO_IDLE) begin
                            if (b != sdspi_pkg::R1_IDLE) begin
                                do_finish = 1'b1;
                                fin_st    = sdspi_pkg::ST_FAIL;
                            end else begin
                                n.retry_counter = 16'd0;
                                do_start   = 1'b1;
                                start_code = sdspi_pkg::CMD_SEND_OP;
                            end
                        end else if (b == sdspi_pkg::R1_READY) begin
                            n.speed_flag = 1'b1;
                            do_finish    = 1'b1;
                            fin_st       = sdspi_pkg::ST_OK;
                        end else if (i_state.retry_counter > i_cfg.init_retry_limit ||
                                     i_state.retry_counter == sdspi_pkg::RETRY_MAX) begin
                            do_finish = 1'b1;
                            fin_st    = sdspi_pkg::ST_FAIL;
                        end else begin
                            n.retry_counter = i_state.retry_counter + 16'd1;
                            do_start   = 1'b1;
                            start_code = sdspi_pkg::CMD_SEND_OP;
                        end
                    end else if (b != sdspi_pkg::R1_READY) begin
                        do_finish = 1'b1;
                        fin_st    = sdspi_pkg::ST_FAIL;
                    end else begin
                        n.byte_counter = '0;
                        case (i_state.kind)
                            sdspi_pkg::KIND_CID:  n.phase = sdspi_pkg::PH_CID_DATA;
                            sdspi_pkg::KIND_READ: n.phase = sdspi_pkg::PH_RD_TOKEN;
                            default:              n.phase = sdspi_pkg::PH_WR_FILL;
                        endcase
                        send = sdspi_pkg::IDLE_BYTE;
                        sv   = 1'b1;
                    end
                end
                sdspi_pkg::PH_CID_DATA: begin
                    n.byte_counter = bc_inc;
                    rv = 1'b1;
                    rb = b;
                    if (bc_inc < sdspi_pkg::BC_W'(sdspi_pkg::CID_BYTES)) begin
                        send = sdspi_pkg::IDLE_BYTE;
                        sv   = 1'b1;
                    end else begin
                        do_finish = 1'b1;
                        fin_st    = sdspi_pkg::ST_OK;
                    end
                end
                sdspi_pkg::PH_RD_TOKEN: begin
                    if (b == sdspi_pkg::DATA_TOKEN) begin
                        n.phase        = sdspi_pkg::PH_RD_DATA;
                        n.byte_counter = '0;
                    end
                    send = sdspi_pkg::IDLE_BYTE;
                    sv   = 1'b1;
                end
                sdspi_pkg::PH_RD_DATA: begin
                    n.byte_counter = bc_inc;
                    if (bc_inc >= sdspi_pkg::BC_W'(sdspi_pkg::BLOCK_BYTES)) begin
                        n.phase        = sdspi_pkg::PH_RD_CRC;
                        n.byte_counter = '0;
                    end
                    send = sdspi_pkg::IDLE_BYTE;
                    sv   = 1'b1;
                    rv   = 1'b1;
                    rb   = b;
                end
                sdspi_pkg::PH_RD_CRC: begin
                    n.byte_counter = bc_inc;
                    if (bc_inc < sdspi_pkg::BC_W'(sdspi_pkg::CRC_BYTES)) begin
                        send = sdspi_pkg::IDLE_BYTE;
                        sv   = 1'b1;
                    end else begin
                        do_finish = 1'b1;
                        fin_st    = sdspi_pkg::ST_OK;
                    end
                end
                sdspi_pkg::PH_WR_FILL: begin
                    n.phase = sdspi_pkg::PH_WR_TOKEN;
                    send = sdspi_pkg::DATA_TOKEN;
                    sv   = 1'b1;
                    nw   = 1'b1;
                end
                sdspi_pkg::PH_WR_TOKEN: begin
                    n.phase        = sdspi_pkg::PH_WR_DATA;
                    n.byte_counter = sdspi_pkg::BC_W'(1);
                    send = i_item.write_byte;
                    sv   = 1'b1;
                    nw   = (1 < sdspi_pkg::BLOCK_BYTES);
                end
                sdspi_pkg::PH_WR_DATA: begin
                    if (i_state.byte_counter < sdspi_pkg::BC_W'(sdspi_pkg::BLOCK_BYTES)) begin
                        n.byte_counter = bc_inc;
                        send = i_item.write_byte;
                        sv   = 1'b1;
                        nw   = (bc_inc < sdspi_pkg::BC_W'(sdspi_pkg::BLOCK_BYTES));
                    end else begin
                        n.phase        = sdspi_pkg::PH_WR_CRC;
                        n.byte_counter = '0;
                        send = sdspi_pkg::IDLE_BYTE;
                        sv   = 1'b1;
                    end
                end
                sdspi_pkg::PH_WR_CRC: begin
                    n.byte_counter = bc_inc;
                    if (bc_inc >= sdspi_pkg::BC_W'(sdspi_pkg::CRC_BYTES))
                        n.phase = sdspi_pkg::PH_WR_RESP;
                    send = sdspi_pkg::IDLE_BYTE;
                    sv   = 1'b1;
                end
                sdspi_pkg::PH_WR_RESP: begin
                    if ((b & sdspi_pkg::RESP_MASK) != sdspi_pkg::RESP_OK) begin
                        do_finish = 1'b1;
                        fin_st    = sdspi_pkg::ST_FAIL;
                    end else begin
                        n.phase = sdspi_pkg::PH_WR_BUSY;
                        send = sdspi_pkg::IDLE_BYTE;
                        sv   = 1'b1;
                    end
                end
                sdspi_pkg::PH_WR_BUSY: begin
                    if (b == sdspi_pkg::BUSY_BYTE) begin
                        send = sdspi_pkg::IDLE_BYTE;
                        sv   = 1'b1;
                    end else begin
                        do_finish = 1'b1;
                        fin_st    = sdspi_pkg::ST_OK;
                    end
                end
                default: begin
                    n.phase = sdspi_pkg::PH_IDLE;
                end
            endcase
        end

        if (do_start) begin
            n.cmd_code     = start_code;
            n.phase        = sdspi_pkg::PH_CMD_IDLE;
            n.select_level = 1'b0;
            n.poll_counter = 8'd0;
            n.byte_counter = '0;
            send = sdspi_pkg::IDLE_BYTE;
            sv   = 1'b1;
            rv   = 1'b0;
            nw   = 1'b0;
        end
        if (do_finish) begin
            n.held_status = fin_st;
            n.phase       = sdspi_pkg::PH_IDLE;
            sv = 1'b0;
            nw = 1'b0;
        end
    end

    assign o_state                  = n;
    assign o_result.send_byte       = sv ? send : 8'h00;
    assign o_result.send_valid      = sv;
    assign o_result.select_active   = n.select_level;
    assign o_result.read_valid      = rv;
    assign o_result.read_byte       = rv ? rb : 8'h00;
    assign o_result.need_write_byte = nw;
    assign o_result.status          = n.held_status;
    assign o_result.fast_clock      = n.speed_flag;

endmodule

// ===== hdl/sd_spi_block_transfer_sequencer_core.sv =====
// Top level of the SD/MMC SPI-mode host byte sequencer: word registers,
// sequencer state and configuration. Uses sdspi_pkg, sdspi_step and the defines header.
//
// Each input word is either a start request (init, block read, block write, CID read)
// or the report of one finished SPI byte exchange; each yields exactly one result word
// naming the next byte to send, chip select, any received data byte and the status.
// A word is taken into an input register, the sequencer state and the result are
// computed combinationally into a result register: one word per clock sustained while
// i_stall is low, bounded by the state update in sdspi_step. Input stall follows the
// output stall only when both registers are full. The configuration (index 0 reply poll
// limit, index 1 init retry limit) is written by the user only while idle, unenforced.
`include "sd_spi_block_transfer_sequencer_core_defines.svh"

module sd_spi_block_transfer_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic [22:0] i_block_address,
    input  logic [7:0]  i_card_byte,
    input  logic [7:0]  i_write_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_send_byte,
    output logic        o_send_valid,
    output logic        o_select_active,
    output logic        o_read_valid,
    output logic [7:0]  o_read_byte,
    output logic        o_need_write_byte,
    output logic [1:0]  o_status,
    output logic        o_fast_clock,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic                r_in_valid;
    sdspi_pkg::t_item    r_in;
    logic                r_out_valid;
    sdspi_pkg::t_result  r_out;
    sdspi_pkg::t_state   r_state;
    sdspi_pkg::t_state   n_state;
    sdspi_pkg::t_result  n_result;
    sdspi_pkg::t_cfg     r_cfg;
    logic                advance;
    logic                in_take;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    sdspi_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.operation     <= i_operation;
            r_in.block_address <= i_block_address;
            r_in.card_byte     <= i_card_byte;
            r_in.write_byte    <= i_write_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= sdspi_pkg::PH_IDLE;
            r_state.kind          <= sdspi_pkg::KIND_INIT;
            r_state.byte_counter  <= '0;
            r_state.poll_counter  <= 8'd0;
            r_state.retry_counter <= 16'd0;
            r_state.byte_address  <= 32'd0;
            r_state.speed_flag    <= 1'b0;
            r_state.cmd_code      <= sdspi_pkg::CMD_GO_IDLE;
            r_state.select_level  <= 1'b0;
            r_state.held_status   <= sdspi_pkg::ST_BUSY;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reply_poll_limit <= sdspi_pkg::POLL_LIMIT_RST;
            r_cfg.init_retry_limit <= sdspi_pkg::RETRY_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sdspi_pkg::CFG_POLL_LIMIT:  r_cfg.reply_poll_limit <= i_cfg_data[7:0];
                sdspi_pkg::CFG_RETRY_LIMIT: r_cfg.init_retry_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_valid           = r_out_valid;
    assign o_send_byte       = r_out.send_byte;
    assign o_send_valid      = r_out.send_valid;
    assign o_select_active   = r_out.select_active;
    assign o_read_valid      = r_out.read_valid;
    assign o_read_byte       = r_out.read_byte;
    assign o_need_write_byte = r_out.need_write_byte;
    assign o_status          = r_out.status;
    assign o_fast_clock      = r_out.fast_clock;

    `SDSPI_ASSERT_ALWAYS(a_done_is_idle,
        r_state.held_status == sdspi_pkg::ST_BUSY || r_state.phase == sdspi_pkg::PH_IDLE)
    `SDSPI_ASSERT_ALWAYS(a_speed_sticky, !$fell(r_state.speed_flag))
    `SDSPI_ASSERT_NEXT(a_fill_output, r_in_valid && !r_out_valid, r_out_valid)
    `SDSPI_ASSERT_NEXT(a_init_wakes, advance && r_in.operation == sdspi_pkg::OP_INIT,
        r_state.phase == sdspi_pkg::PH_WAKE && !r_state.select_level)

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for sd_spi_block_transfer_sequencer_core: a card model feeds the
// sequencer, a scoreboard predicts every result word and compares it field by field.
// Depends on sdspi_pkg and the core RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sdspi_pkg::*;

    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_WORDS = 207;

    class sequencer_scoreboard;
        t_phase      phase;
        t_kind       kind;
        int unsigned byte_cnt;
        logic [7:0]  poll_cnt;
        logic [15:0] retry_cnt;
        logic [31:0] byte_addr;
        logic        speed;
        logic [5:0]  cmd;
        logic        sel;
        logic [1:0]  held_st;
        logic [7:0]  poll_limit;
        logic [15:0] retry_limit;
        t_result     results_due[$];
        int          errors;
        int          checked;
        int          starts;
        int          aborts;
        int          data_bytes;
        int          ok_by_kind[4];
        int          fail_by_kind[4];

        function new();
            phase       = PH_IDLE;
            kind        = KIND_INIT;
            byte_cnt    = 0;
            poll_cnt    = '0;
            retry_cnt   = '0;
            byte_addr   = '0;
            speed       = 1'b0;
            cmd         = CMD_GO_IDLE;
            sel         = 1'b0;
            held_st     = ST_BUSY;
            poll_limit  = POLL_LIMIT_RST;
            retry_limit = RETRY_LIMIT_RST;
            errors      = 0;
            checked     = 0;
            starts      = 0;
            aborts      = 0;
            data_bytes  = 0;
            for (int k = 0; k < 4; k++) begin
                ok_by_kind[k]   = 0;
                fail_by_kind[k] = 0;
            end
        endfunction

        function void set_limits(logic [7:0] poll, logic [15:0] retry);
            poll_limit  = poll;
            retry_limit = retry;
        endfunction

        function t_result emit(logic [7:0] send, logic valid, logic rv, logic [7:0] rb,
                               logic nw);
            t_result r;
            r.send_byte       = valid ? send : 8'h00;
            r.send_valid      = valid;
            r.select_active   = sel;
            r.read_valid      = rv;
            r.read_byte       = rv ? rb : 8'h00;
            r.need_write_byte = nw;
            r.status          = held_st;
            r.fast_clock      = speed;
            return r;
        endfunction

        function t_result conclude(logic [1:0] st, logic rv, logic [7:0] rb);
            held_st = st;
            phase   = PH_IDLE;
            if (st == ST_OK)
                ok_by_kind[int'(kind)]++;
            else
                fail_by_kind[int'(kind)]++;
            return emit(8'h00, 1'b0, rv, rb, 1'b0);
        endfunction

        function logic [7:0] cmd_byte(int unsigned idx);
            if (idx == 0)
                return {CMD_PREFIX, cmd};
            if (idx <= 4)
                return 8'(byte_addr >> (8 * (4 - idx)));
            return (cmd == CMD_GO_IDLE) ? CRC_CMD0 : IDLE_BYTE;
        endfunction

        function t_result start_cmd(logic [5:0] code);
            cmd      = code;
            phase    = PH_CMD_IDLE;
            sel      = 1'b0;
            poll_cnt = '0;
            byte_cnt = 0;
            return emit(IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0);
        endfunction

        function t_result take_reply(logic [7:0] reply);
            if (kind == KIND_INIT) begin
                if (cmd == CMD_GO_IDLE) begin
                    if (reply != R1_IDLE)
                        return conclude(ST_FAIL, 1'b0, 8'h00);
                    retry_cnt = '0;
                    return start_cmd(CMD_SEND_OP);
                end
                if (reply == R1_READY) begin
                    speed = 1'b1;
                    return conclude(ST_OK, 1'b0, 8'h00);
                end
                if (retry_cnt > retry_limit || retry_cnt >= RETRY_MAX)
                    return conclude(ST_FAIL, 1'b0, 8'h00);
                retry_cnt++;
                return start_cmd(CMD_SEND_OP);
            end
            if (reply != R1_READY)
                return conclude(ST_FAIL, 1'b0, 8'h00);
            byte_cnt = 0;
            if (kind == KIND_CID)
                phase = PH_CID_DATA;
            else if (kind == KIND_READ)
                phase = PH_RD_TOKEN;
            else
                phase = PH_WR_FILL;
            return emit(IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0);
        endfunction

        function t_result step_sequencer(t_item it);
            logic [7:0] cb;
            logic [7:0] wb;
            logic [7:0] out_byte;
            cb = it.card_byte;
            wb = it.write_byte;
            if (it.operation inside {OP_INIT, OP_READ, OP_WRITE, OP_CID}) begin
                starts++;
                if (phase != PH_IDLE)
                    aborts++;
                held_st   = ST_BUSY;
                retry_cnt = '0;
                byte_cnt  = 0;
                if (it.operation == OP_INIT) begin
                    kind      = KIND_INIT;
                    byte_addr = '0;
                    sel       = 1'b0;
                    phase     = PH_WAKE;
                    return emit(IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0);
                end
                if (it.operation == OP_CID) begin
                    kind      = KIND_CID;
                    byte_addr = '0;
                    return start_cmd(CMD_SEND_CID);
                end
                byte_addr = 32'(it.block_address) << BLOCK_SHIFT;
                if (it.operation == OP_READ) begin
                    kind = KIND_READ;
                    return start_cmd(CMD_READ_ONE);
                end
                kind = KIND_WRITE;
                return start_cmd(CMD_WRITE_ONE);
            end
            if (it.operation != OP_XCHG || phase == PH_IDLE)
                return emit(8'h00, 1'b0, 1'b0, 8'h00, 1'b0);

            case (phase)
                PH_WAKE: begin
                    byte_cnt++;
                    if (byte_cnt < WAKE_BYTES)
                        return emit(IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0);
                    return start_cmd(CMD_GO_IDLE);
                end
                PH_CMD_IDLE: begin
                    sel      = 1'b1;
                    phase    = PH_CMD_SEND;
                    byte_cnt = 1;
                    return emit(cmd_byte(0), 1'b1, 1'b0, 8'h00, 1'b0);
                end
                PH_CMD_SEND: begin
                    if (byte_cnt < CMD_BYTES) begin
                        out_byte = cmd_byte(byte_cnt);
                        byte_cnt++;
                        return emit(out_byte, 1'b1, 1'b0, 8'h00, 1'b0);
                    end
                    phase    = PH_CMD_POLL;
                    poll_cnt = '0;
                    return emit(IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0);
                end
                PH_CMD_POLL: begin
                    if (cb == IDLE_BYTE && poll_cnt < poll_limit) begin
                        poll_cnt++;
                        return emit(IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0);
                    end
                    return take_reply(cb);
                end
                PH_CID_DATA: begin
                    byte_cnt++;
                    if (byte_cnt < CID_BYTES)
                        return emit(IDLE_BYTE, 1'b1, 1'b1, cb, 1'b0);
                    return conclude(ST_OK, 1'b1, cb);
                end
                PH_RD_TOKEN: begin
                    if (cb == DATA_TOKEN) begin
                        phase    = PH_RD_DATA;
                        byte_cnt = 0;
                    end
                    return emit(IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0);
                end
                PH_RD_DATA: begin
                    byte_cnt++;
                    if (byte_cnt >= BLOCK_BYTES) begin
                        phase    = PH_RD_CRC;
                        byte_cnt = 0;
                    end
                    return emit(IDLE_BYTE, 1'b1, 1'b1, cb, 1'b0);
                end
                PH_RD_CRC: begin
                    byte_cnt++;
                    if (byte_cnt < CRC_BYTES)
                        return emit(IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0);
                    return conclude(ST_OK, 1'b0, 8'h00);
                end
                PH_WR_FILL: begin
                    phase = PH_WR_TOKEN;
                    return emit(DATA_TOKEN, 1'b1, 1'b0, 8'h00, 1'b1);
                end
                PH_WR_TOKEN: begin
                    phase    = PH_WR_DATA;
                    byte_cnt = 1;
                    return emit(wb, 1'b1, 1'b0, 8'h00, (BLOCK_BYTES > 1));
                end
                PH_WR_DATA: begin
                    if (byte_cnt < BLOCK_BYTES) begin
                        byte_cnt++;
                        return emit(wb, 1'b1, 1'b0, 8'h00, (byte_cnt < BLOCK_BYTES));
                    end
                    phase    = PH_WR_CRC;
                    byte_cnt = 0;
                    return emit(IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0);
                end
                PH_WR_CRC: begin
                    byte_cnt++;
                    if (byte_cnt >= CRC_BYTES)
                        phase = PH_WR_RESP;
                    return emit(IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0);
                end
                PH_WR_RESP: begin
                    if ((cb & RESP_MASK) != RESP_OK)
                        return conclude(ST_FAIL, 1'b0, 8'h00);
                    phase = PH_WR_BUSY;
                    return emit(IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0);
                end
                PH_WR_BUSY: begin
                    if (cb == BUSY_BYTE)
                        return emit(IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0);
                    return conclude(ST_OK, 1'b0, 8'h00);
                end
                default: begin
                    phase = PH_IDLE;
                    return emit(8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
                end
            endcase
        endfunction

        function void note_word(t_item it);
            t_result r;
            r = step_sequencer(it);
            if (r.read_valid)
                data_bytes++;
            results_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %p", $time, got);
                errors++;
                return;
            end
            want = results_due.pop_front();
            checked++;
            compare_field("send_byte", want.send_byte, got.send_byte);
            compare_field("send_valid", want.send_valid, got.send_valid);
            compare_field("select_active", want.select_active, got.select_active);
            compare_field("read_valid", want.read_valid, got.read_valid);
            compare_field("read_byte", want.read_byte, got.read_byte);
            compare_field("need_write_byte", want.need_write_byte, got.need_write_byte);
            compare_field("status", want.status, got.status);
            compare_field("fast_clock", want.fast_clock, got.fast_clock);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_operation = OP_XCHG;
    logic [22:0] i_block_address = '0;
    logic [7:0]  i_card_byte = '0;
    logic [7:0]  i_write_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_send_byte;
    logic        o_send_valid;
    logic        o_select_active;
    logic        o_read_valid;
    logic [7:0]  o_read_byte;
    logic        o_need_write_byte;
    logic [1:0]  o_status;
    logic        o_fast_clock;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_POLL_LIMIT;
    logic [15:0] i_cfg_data = '0;

    sequencer_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int words_counted = 0;
    int poll_delay = 0;
    int quiet_cycles = 0;

    sd_spi_block_transfer_sequencer_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_block_address  (i_block_address),
        .i_card_byte      (i_card_byte),
        .i_write_byte     (i_write_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_send_byte      (o_send_byte),
        .o_send_valid     (o_send_valid),
        .o_select_active  (o_select_active),
        .o_read_valid     (o_read_valid),
        .o_read_byte      (o_read_byte),
        .o_need_write_byte(o_need_write_byte),
        .o_status         (o_status),
        .o_fast_clock     (o_fast_clock),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            sb.check_word(t_result'{o_send_byte, o_send_valid, o_select_active, o_read_valid,
                                    o_read_byte, o_need_write_byte, o_status, o_fast_clock});
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // card side: mostly well-formed replies, with timeouts and bad replies mixed in
    function automatic logic [7:0] card_answer();
        int roll;
        roll = $urandom_range(99);
        case (sb.phase)
            PH_CMD_POLL: begin
                if (sb.poll_cnt == 0) begin
                    if (roll < 60)
                        poll_delay = 0;
                    else if (roll < 85)
                        poll_delay = $urandom_range(4, 1);
                    else if (roll < 95)
                        poll_delay = $urandom_range(12, 5);
                    else
                        poll_delay = 300;
                    roll = $urandom_range(99);
                end
                if (sb.poll_cnt < poll_delay)
                    return IDLE_BYTE;
                if (sb.kind == KIND_INIT && sb.cmd == CMD_GO_IDLE)
                    return (roll < 90) ? R1_IDLE : 8'($urandom);
                if (sb.kind == KIND_INIT)
                    return (roll < 40) ? R1_READY : (roll < 90) ? R1_IDLE : 8'($urandom);
                return (roll < 85) ? R1_READY : 8'($urandom);
            end
            PH_RD_TOKEN:
                return (roll < 25) ? DATA_TOKEN : (roll < 90) ? IDLE_BYTE : 8'($urandom);
            PH_WR_RESP:
                return (roll < 80) ? {3'($urandom_range(7)), RESP_OK[4:0]} : 8'($urandom);
            PH_WR_BUSY:
                return (roll < 60) ? BUSY_BYTE : 8'($urandom);
            default:
                return 8'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [2:0] op, input logic [22:0] blk,
                             input logic [7:0] cb, input logic [7:0] wb);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        words_counted++;
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_block_address <= blk;
        i_card_byte     <= cb;
        i_write_byte    <= wb;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_word(t_item'{op, blk, cb, wb});
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] poll, input logic [15:0] retry);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_POLL_LIMIT;
        i_cfg_data  <= {8'h00, poll};
        @(posedge i_clk);
        i_cfg_index <= CFG_RETRY_LIMIT;
        i_cfg_data  <= retry;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limits(poll, retry);
    endtask

    task automatic run_random(input int target);
        int first;
        int roll;
        logic [2:0] op;
        first = words_counted;
        while (words_counted - first < target) begin
            if ($urandom_range(999) < 8)
                wait_results_drained();
            if (sb.phase == PH_IDLE) begin
                roll = $urandom_range(99);
                if (roll < 34)
                    op = OP_INIT;
                else if (roll < 68)
                    op = OP_CID;
                else if (roll < 78)
                    op = OP_READ;
                else if (roll < 88)
                    op = OP_WRITE;
                else if (roll < 94)
                    op = OP_XCHG;
                else
                    op = 3'($urandom_range(OP_SPARE_7, OP_SPARE_5));
            end else begin
                roll = $urandom_range(999);
                if (roll < 3)
                    op = 3'($urandom_range(OP_CID, OP_INIT));
                else if (roll < 10)
                    op = 3'($urandom_range(OP_SPARE_7, OP_SPARE_5));
                else
                    op = OP_XCHG;
            end
            send_word(op, 23'($urandom), (op == OP_XCHG) ? card_answer() : 8'($urandom),
                      8'($urandom));
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [7:0] poll,
                             input logic [15:0] retry);
        wait_results_drained();
        idle_pct  = idle;
        stall_pct = stall;
        configure(poll, retry);
        run_random(PHASE_WORDS);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ignored words, then a read aborted by a write, a CID read and an init
        send_word(OP_XCHG, 23'h7FFFFF, 8'hFF, 8'hFF);
        send_word(OP_SPARE_5, 23'h000000, 8'h00, 8'h00);
        send_word(OP_SPARE_6, 23'h7FFFFF, 8'hFF, 8'hFF);
        send_word(OP_SPARE_7, 23'h000000, 8'h00, 8'h00);
        send_word(OP_READ, 23'h7FFFFF, 8'hFF, 8'hFF);
        repeat (7) send_word(OP_XCHG, 23'h000000, 8'h00, 8'h00);
        send_word(OP_SPARE_7, 23'h7FFFFF, 8'hFF, 8'hFF);
        send_word(OP_XCHG, 23'h000000, IDLE_BYTE, 8'h00);
        send_word(OP_XCHG, 23'h000000, R1_READY, 8'h00);
        send_word(OP_XCHG, 23'h000000, IDLE_BYTE, 8'hFF);
        send_word(OP_WRITE, 23'h000000, 8'h00, 8'h00);
        send_word(OP_CID, 23'h7FFFFF, 8'hFF, 8'hFF);
        send_word(OP_INIT, 23'h000000, 8'h00, 8'h00);
        send_word(OP_XCHG, 23'h7FFFFF, 8'h00, 8'hFF);
        send_word(OP_XCHG, 23'h000000, 8'hFF, 8'h00);

        run_phase(0, 0, 8'd0, 16'd0);
        run_phase(52, 0, 8'd255, 16'hFFFF);
        run_phase(0, 52, 8'd3, 16'd2);
        run_phase(30, 30, 8'd12, 16'd9);

        wait_results_drained();
        repeat (8) @(posedge i_clk);

        $display("summary: %0d words, %0d starts (%0d aborting a transfer), %0d results checked",
                 words_counted, sb.starts, sb.aborts, sb.checked);
        $display("summary: ok/fail init %0d/%0d cid %0d/%0d read %0d/%0d write %0d/%0d,",
                 sb.ok_by_kind[int'(KIND_INIT)], sb.fail_by_kind[int'(KIND_INIT)],
                 sb.ok_by_kind[int'(KIND_CID)], sb.fail_by_kind[int'(KIND_CID)],
                 sb.ok_by_kind[int'(KIND_READ)], sb.fail_by_kind[int'(KIND_READ)],
                 sb.ok_by_kind[int'(KIND_WRITE)], sb.fail_by_kind[int'(KIND_WRITE)]);
        $display("summary: %0d data bytes received", sb.data_bytes);
        if (sb.errors == 0 && sb.results_due.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
